>>> sv/ssdw_pkg.sv
// Shared types, constants and the segment glyph table of the two-wire
// display writer. No dependencies.
package ssdw_pkg;

    localparam int DIGITS      = 4;
    localparam int TEXT_FIELDS = 4;
    localparam int TXT_MAX     = (DIGITS < TEXT_FIELDS) ? DIGITS : TEXT_FIELDS;
    localparam int NPOS        = (DIGITS > TEXT_FIELDS) ? DIGITS : TEXT_FIELDS;
    localparam int POS_W       = (NPOS > 1) ? $clog2(NPOS) : 1;
    localparam int CNT_W       = $clog2(NPOS + 1);
    localparam int STEP_W      = $clog2(NPOS + 2);

    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [1:0] CMD_RAW  = 2'd0;
    localparam logic [1:0] CMD_TEXT = 2'd1;
    localparam logic [1:0] CMD_NUM  = 2'd2;

    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_BIT   = 2'd1;
    localparam logic [1:0] EV_ACK   = 2'd2;
    localparam logic [1:0] EV_STOP  = 2'd3;

    localparam logic [7:0] BYTE_DATA_AUTO  = 8'h40;
    localparam logic [7:0] BYTE_ADDR_FIRST = 8'hC0;
    localparam logic [7:0] SEP_BIT         = 8'h80;
    localparam logic [6:0] ASCII_ZERO      = 7'h30;

    localparam logic [16:0] RECIP_TEN = 17'd52429;
    localparam int          RECIP_SH  = 19;

    typedef struct packed {
        logic       start;
        logic       stop;
        logic       last;
        logic [7:0] data;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [7:0] letter_code(input logic [4:0] l);
        logic [7:0] s;
        case (l)
            5'd1:    s = 8'h77;
            5'd2:    s = 8'h7c;
            5'd3:    s = 8'h39;
            5'd4:    s = 8'h5e;
            5'd5:    s = 8'h79;
            5'd6:    s = 8'h71;
            5'd7:    s = 8'h3d;
            5'd8:    s = 8'h76;
            5'd9:    s = 8'h04;
            5'd10:   s = 8'h1e;
            5'd11:   s = 8'h75;
            5'd12:   s = 8'h38;
            5'd13:   s = 8'h49;
            5'd14:   s = 8'h54;
            5'd15:   s = 8'h5c;
            5'd16:   s = 8'h73;
            5'd17:   s = 8'h67;
            5'd18:   s = 8'h50;
            5'd19:   s = 8'h6d;
            5'd20:   s = 8'h78;
            5'd21:   s = 8'h1c;
            5'd22:   s = 8'h3e;
            5'd23:   s = 8'h7e;
            5'd24:   s = 8'h76;
            5'd25:   s = 8'h6e;
            5'd26:   s = 8'h5b;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] digit_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // 7-bit ASCII to segments; letters are case-blind, no glyph gives blank
    function automatic logic [7:0] seg_code(input logic [6:0] c);
        logic [7:0] s;
        case (c) inside
            7'h2C, 7'h2E, 7'h5F: s = 8'h08;
            7'h2D:               s = 8'h40;
            [7'h30:7'h39]:       s = digit_code(c[3:0]);
            [7'h41:7'h5A]:       s = letter_code(c[4:0]);
            [7'h61:7'h7A]:       s = letter_code(c[4:0]);
            default:             s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

>>> sv/ssdw_front.sv
// Command front end: takes one command, converts numbers to digits and
// queues one byte descriptor per transmitted byte. Depends on ssdw_pkg.
module ssdw_front import ssdw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_raw_byte,
    input  logic [6:0] i_char0,
    input  logic [6:0] i_char1,
    input  logic [6:0] i_char2,
    input  logic [6:0] i_char3,
    input  logic [2:0] i_char_count,
    input  logic [15:0] i_number,
    input  logic       i_separator,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_entry     o_entry
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIG  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        r_state;
    logic              r_raw_mode;
    logic [7:0]        r_raw;
    logic [6:0]        r_chr [NPOS];
    logic [CNT_W-1:0]  r_cnt;
    logic              r_sep;
    logic [15:0]       r_num;
    logic [POS_W-1:0]  r_k;
    logic [STEP_W-1:0] r_step;

    logic              w_accept;
    logic [6:0]        w_chars [TEXT_FIELDS];
    logic [2:0]        w_cnt_clamp;
    logic [32:0]       w_prod;
    logic [15:0]       w_quot;
    logic [3:0]        w_digit;
    logic [POS_W-1:0]  w_dig_pos;
    logic [POS_W-1:0]  w_idx;
    logic [7:0]        w_seg;
    logic [STEP_W-1:0] w_last_step;
    logic              w_done;
    logic              w_final_chr;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);

    assign w_chars[0] = i_char0;
    assign w_chars[1] = i_char1;
    assign w_chars[2] = i_char2;
    assign w_chars[3] = i_char3;

    assign w_cnt_clamp = (i_char_count > 3'(TXT_MAX)) ? 3'(TXT_MAX) : i_char_count;

    assign w_prod    = r_num * RECIP_TEN;
    assign w_quot    = w_prod[RECIP_SH +: 16];
    assign w_digit   = 4'(r_num - ((w_quot << 3) + (w_quot << 1)));
    assign w_dig_pos = POS_W'(DIGITS - 1) - r_k;

    assign w_idx       = POS_W'(r_step - STEP_W'(2));
    assign w_seg       = seg_code(r_chr[w_idx]);
    assign w_last_step = r_raw_mode ? '0 : STEP_W'(r_cnt) + STEP_W'(1);
    assign w_done      = (r_step == w_last_step);
    assign w_final_chr = (STEP_W'(w_idx) == STEP_W'(r_cnt) - STEP_W'(1));

    always_comb begin
        o_entry = '0;
        if (r_raw_mode) begin
            o_entry = '{start: 1'b1, stop: 1'b1, last: 1'b1, data: r_raw};
        end else if (r_step == STEP_W'(0)) begin
            o_entry = '{start: 1'b1, stop: 1'b1, last: 1'b0, data: BYTE_DATA_AUTO};
        end else if (r_step == STEP_W'(1)) begin
            o_entry.start = 1'b1;
            o_entry.stop  = (r_cnt == '0);
            o_entry.last  = (r_cnt == '0);
            o_entry.data  = BYTE_ADDR_FIRST;
        end else begin
            o_entry.start = 1'b0;
            o_entry.stop  = w_final_chr;
            o_entry.last  = w_final_chr;
            o_entry.data  = w_seg | ((r_sep && w_idx == POS_W'(1)) ? SEP_BIT : 8'h00);
        end
    end

    assign o_push = (r_state == S_EMIT) && !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_command == CMD_RAW || i_command == CMD_TEXT) begin
                            r_state <= S_EMIT;
                        end else if (i_command == CMD_NUM) begin
                            r_state <= S_DIG;
                        end
                    end
                end
                S_DIG: begin
                    if (r_k == POS_W'(DIGITS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (o_push && w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw_mode <= (i_command == CMD_RAW);
            r_raw      <= i_raw_byte;
            r_sep      <= i_separator;
            r_num      <= i_number;
            r_k        <= '0;
            r_step     <= '0;
            if (i_command == CMD_NUM) begin
                r_cnt <= CNT_W'(DIGITS);
            end else begin
                r_cnt <= CNT_W'(w_cnt_clamp);
                for (int i = 0; i < NPOS; i++) begin
                    r_chr[i] <= (i < TEXT_FIELDS) ? w_chars[i] : 7'h00;
                end
            end
        end else if (r_state == S_DIG) begin
            r_chr[w_dig_pos] <= ASCII_ZERO + 7'(w_digit);
            r_num            <= w_quot;
            r_k              <= r_k + POS_W'(1);
        end else if (o_push) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

endmodule

>>> sv/ssdw_fifo.sv
// Short queue of byte descriptors between the front end and the event
// sequencer. Depends on ssdw_pkg.
module ssdw_fifo import ssdw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output t_qstat o_qstat
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_entry       = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

>>> sv/ssdw_back.sv
// Event sequencer: plays each byte descriptor out as an optional start, eight
// data bits, ack slot, optional stop into the output register. Uses ssdw_pkg.
module ssdw_back import ssdw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qstat     i_qstat,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_kind,
    output logic       o_bit_value,
    output logic       o_last
);

    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_BIT0  = 4'd1;
    localparam logic [3:0] PH_BIT7  = 4'd8;
    localparam logic [3:0] PH_ACK   = 4'd9;
    localparam logic [3:0] PH_STOP  = 4'd10;

    logic       r_busy;
    t_entry     r_ent;
    logic [3:0] r_ph;
    logic       r_ov;
    logic [1:0] r_kind;
    logic       r_bit;
    logic       r_last;

    logic       w_load;
    logic [2:0] w_bit_idx;

    assign w_load    = !r_ov || !i_stall;
    assign o_pop     = !r_busy && !i_qstat.empty;
    assign w_bit_idx = 3'(r_ph - PH_BIT0);

    assign o_valid      = r_ov;
    assign o_event_kind = r_kind;
    assign o_bit_value  = r_bit;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_ent  <= i_entry;
                r_ph   <= i_entry.start ? PH_START : PH_BIT0;
                if (w_load) begin
                    r_ov <= 1'b0;
                end
            end else if (r_busy && w_load) begin
                r_ov <= 1'b1;
                if (r_ph == PH_START) begin
                    r_kind <= EV_START;
                    r_bit  <= 1'b0;
                    r_last <= 1'b0;
                    r_ph   <= PH_BIT0;
                end else if (r_ph <= PH_BIT7) begin
                    r_kind <= EV_BIT;
                    r_bit  <= r_ent.data[w_bit_idx];
                    r_last <= 1'b0;
                    r_ph   <= r_ph + 4'd1;
                end else if (r_ph == PH_ACK) begin
                    r_kind <= EV_ACK;
                    r_bit  <= 1'b0;
                    r_last <= r_ent.last && !r_ent.stop;
                    if (r_ent.stop) begin
                        r_ph <= PH_STOP;
                    end else begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_kind <= EV_STOP;
                    r_bit  <= 1'b0;
                    r_last <= r_ent.last;
                    r_busy <= 1'b0;
                end
            end else if (w_load) begin
                r_ov <= 1'b0;
            end
        end
    end

    a_bit_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind != EV_BIT) |-> !r_bit)
        else $error("nonzero line level on a non-data event");

    a_last_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> (r_kind == EV_STOP))
        else $error("final event of a command is not a stop");

    a_start_then_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_stall && r_kind == EV_START) |=> (r_ov && r_kind == EV_BIT))
        else $error("start not followed by a data bit");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_ph <= PH_STOP))
        else $error("sequencer phase out of range");

endmodule

>>> sv/seven_segment_serial_display_writer_unit.sv
// Two-wire seven-segment display writer: one command in, a stream of link
// events (start, data bit, ack slot, stop) out, one event per beat; last marks
// the final beat of a command. The event sequencer emits one event per cycle
// while the receiver does not stall and pauses to take each byte from the
// queue; number conversion yields one decimal digit per cycle before queueing.
// A new command is accepted once the front end has queued all bytes of the
// previous one. Command 3 is accepted and produces nothing.
// Depends on ssdw_pkg, ssdw_front, ssdw_fifo, ssdw_back.
module seven_segment_serial_display_writer_unit import ssdw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_raw_byte,
    input  logic [6:0]  i_char0,
    input  logic [6:0]  i_char1,
    input  logic [6:0]  i_char2,
    input  logic [6:0]  i_char3,
    input  logic [2:0]  i_char_count,
    input  logic [15:0] i_number,
    input  logic        i_separator,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_kind,
    output logic        o_bit_value,
    output logic        o_last
);

    t_qstat w_qstat;
    t_entry w_push_entry;
    t_entry w_head_entry;
    logic   w_push;
    logic   w_pop;

    ssdw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_raw_byte   (i_raw_byte),
        .i_char0      (i_char0),
        .i_char1      (i_char1),
        .i_char2      (i_char2),
        .i_char3      (i_char3),
        .i_char_count (i_char_count),
        .i_number     (i_number),
        .i_separator  (i_separator),
        .i_qstat      (w_qstat),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    ssdw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_qstat (w_qstat)
    );

    ssdw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qstat      (w_qstat),
        .i_entry      (w_head_entry),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_bit_value  (o_bit_value),
        .o_last       (o_last)
    );

endmodule

>>> tb/sv/ssdw_link_event_checker.sv
// Watches both channels of the two-wire display writer, expands each accepted
// command into the link events it must produce and compares every output beat.
// Depends on ssdw_pkg for the command and event codes and the fixed link bytes.
module ssdw_link_event_checker import ssdw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_raw_byte,
    input  logic [6:0]  i_char0,
    input  logic [6:0]  i_char1,
    input  logic [6:0]  i_char2,
    input  logic [6:0]  i_char3,
    input  logic [2:0]  i_char_count,
    input  logic [15:0] i_number,
    input  logic        i_separator,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_event_kind,
    input  logic        i_bit_value,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_events_due
);

    localparam int SHOWN_DIGITS = 4;
    localparam int NUM_MODULUS  = 10000;

    typedef struct packed {
        logic [1:0] kind;
        logic       bit_value;
        logic       last;
    } t_link_event;

    t_link_event events_due[$];
    t_link_event head;
    int          events_left;
    int          fails = 0;

    function automatic logic [7:0] glyph_of(input logic [6:0] c);
        logic [7:0] g;
        int         idx;
        g   = 8'h00;
        idx = -1;
        if (c >= 7'h41 && c <= 7'h5A) begin
            idx = c - 7'h41;
        end else if (c >= 7'h61 && c <= 7'h7A) begin
            idx = c - 7'h61;
        end
        if (idx >= 0) begin
            case (idx)
                0:  g = 8'h77;  1:  g = 8'h7c;  2:  g = 8'h39;  3:  g = 8'h5e;
                4:  g = 8'h79;  5:  g = 8'h71;  6:  g = 8'h3d;  7:  g = 8'h76;
                8:  g = 8'h04;  9:  g = 8'h1e;  10: g = 8'h75;  11: g = 8'h38;
                12: g = 8'h49;  13: g = 8'h54;  14: g = 8'h5c;  15: g = 8'h73;
                16: g = 8'h67;  17: g = 8'h50;  18: g = 8'h6d;  19: g = 8'h78;
                20: g = 8'h1c;  21: g = 8'h3e;  22: g = 8'h7e;  23: g = 8'h76;
                24: g = 8'h6e;  25: g = 8'h5b;
                default: g = 8'h00;
            endcase
        end else if (c >= 7'h30 && c <= 7'h39) begin
            case (c[3:0])
                4'd0: g = 8'h3f;  4'd1: g = 8'h06;  4'd2: g = 8'h5b;  4'd3: g = 8'h4f;
                4'd4: g = 8'h66;  4'd5: g = 8'h6d;  4'd6: g = 8'h7d;  4'd7: g = 8'h07;
                4'd8: g = 8'h7f;  4'd9: g = 8'h6f;
                default: g = 8'h00;
            endcase
        end else if (c == 7'h2C || c == 7'h2E || c == 7'h5F) begin
            g = 8'h08;
        end else if (c == 7'h2D) begin
            g = 8'h40;
        end
        return g;
    endfunction

    task automatic due_event(input logic [1:0] kind, input logic b);
        t_link_event e;
        e.kind      = kind;
        e.bit_value = b;
        e.last      = (events_left == 1);
        events_due.push_back(e);
        events_left--;
    endtask

    task automatic due_octet(input logic [7:0] octet);
        for (int i = 0; i < 8; i++) begin
            due_event(EV_BIT, octet[i]);
        end
        due_event(EV_ACK, 1'b0);
    endtask

    task automatic expand_command(
        input logic [1:0]      cmd,
        input logic [7:0]      raw,
        input logic [3:0][6:0] chars,
        input logic [2:0]      cnt,
        input logic [15:0]     num,
        input logic            sep
    );
        logic [3:0][6:0] codes;
        logic [7:0]      segs;
        int              n;
        int              v;
        case (cmd)
            CMD_RAW: begin
                events_left = 11;
                due_event(EV_START, 1'b0);
                due_octet(raw);
                due_event(EV_STOP, 1'b0);
            end
            CMD_TEXT, CMD_NUM: begin
                if (cmd == CMD_TEXT) begin
                    n     = (cnt > SHOWN_DIGITS) ? SHOWN_DIGITS : cnt;
                    codes = chars;
                end else begin
                    n = SHOWN_DIGITS;
                    v = num % NUM_MODULUS;
                    for (int i = 0; i < SHOWN_DIGITS; i++) begin
                        codes[SHOWN_DIGITS - 1 - i] = ASCII_ZERO + 7'(v % 10);
                        v = v / 10;
                    end
                end
                events_left = 22 + 9 * n;
                due_event(EV_START, 1'b0);
                due_octet(BYTE_DATA_AUTO);
                due_event(EV_STOP, 1'b0);
                due_event(EV_START, 1'b0);
                due_octet(BYTE_ADDR_FIRST);
                for (int i = 0; i < n; i++) begin
                    segs = glyph_of(codes[i]);
                    if (i == 1 && sep) begin
                        segs = segs | SEP_BIT;
                    end
                    due_octet(segs);
                end
                due_event(EV_STOP, 1'b0);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expand_command(i_command, i_raw_byte, {i_char3, i_char2, i_char1, i_char0},
                               i_char_count, i_number, i_separator);
            end
            if (i_out_valid && !i_out_stall) begin
                if (events_due.size() == 0) begin
                    $error("event_kind: expected none, got %0d", i_event_kind);
                    fails++;
                end else begin
                    head = events_due.pop_front();
                    if (i_event_kind !== head.kind) begin
                        $error("event_kind: expected %0d, got %0d", head.kind, i_event_kind);
                        fails++;
                    end
                    if (i_bit_value !== head.bit_value) begin
                        $error("bit_value: expected %0d, got %0d", head.bit_value, i_bit_value);
                        fails++;
                    end
                    if (i_last !== head.last) begin
                        $error("last: expected %0d, got %0d", head.last, i_last);
                        fails++;
                    end
                end
            end
        end
        o_events_due <= events_due.size();
    end

    initial o_events_due = 0;
    assign o_fail_count = fails;

endmodule

>>> tb/sv/tb_seven_segment_serial_display_writer_unit.sv
// Top of the display writer testbench: clock, reset, command stimulus and the
// receiver's stall pattern; the verdict comes from ssdw_link_event_checker.
// Depends on ssdw_pkg, seven_segment_serial_display_writer_unit and the checker.
module tb_seven_segment_serial_display_writer_unit;
    import ssdw_pkg::*;

    localparam logic [1:0] CMD_IDLE  = 2'd3;
    localparam int         HOLD_LEN  = 300;
    localparam int         PER_PHASE = 67;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command    = CMD_RAW;
    logic [7:0]  i_raw_byte   = 8'h00;
    logic [6:0]  i_char0      = 7'h00;
    logic [6:0]  i_char1      = 7'h00;
    logic [6:0]  i_char2      = 7'h00;
    logic [6:0]  i_char3      = 7'h00;
    logic [2:0]  i_char_count = 3'd0;
    logic [15:0] i_number     = 16'd0;
    logic        i_separator  = 1'b0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [1:0]  o_event_kind;
    logic        o_bit_value;
    logic        o_last;

    int   send_idle  = 8;
    int   recv_idle  = 57;
    logic hold_req   = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;
    int   fail_count;
    int   events_due;

    seven_segment_serial_display_writer_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_raw_byte   (i_raw_byte),
        .i_char0      (i_char0),
        .i_char1      (i_char1),
        .i_char2      (i_char2),
        .i_char3      (i_char3),
        .i_char_count (i_char_count),
        .i_number     (i_number),
        .i_separator  (i_separator),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_kind (o_event_kind),
        .o_bit_value  (o_bit_value),
        .o_last       (o_last)
    );

    ssdw_link_event_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_command    (i_command),
        .i_raw_byte   (i_raw_byte),
        .i_char0      (i_char0),
        .i_char1      (i_char1),
        .i_char2      (i_char2),
        .i_char3      (i_char3),
        .i_char_count (i_char_count),
        .i_number     (i_number),
        .i_separator  (i_separator),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_event_kind (o_event_kind),
        .i_bit_value  (o_bit_value),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_events_due (events_due)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        hold_seen <= hold_req;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // text holds the characters first to last, one per byte, MSB byte first
    task automatic offer(
        input logic [1:0]  cmd,
        input logic [7:0]  raw,
        input logic [31:0] text,
        input logic [2:0]  cnt,
        input logic [15:0] num,
        input logic        sep
    );
        logic took;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_raw_byte   <= raw;
        i_char0      <= text[30:24];
        i_char1      <= text[22:16];
        i_char2      <= text[14:8];
        i_char3      <= text[6:0];
        i_char_count <= cnt;
        i_number     <= num;
        i_separator  <= sep;
        do begin
            @(negedge i_clk);
            took = !o_stall;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic offer_random();
        int          r;
        logic [1:0]  cmd;
        logic [7:0]  raw;
        logic [31:0] text;
        logic [2:0]  cnt;
        logic [15:0] num;
        logic        sep;
        r    = $urandom_range(99);
        cmd  = (r < 5) ? CMD_IDLE : (r < 30) ? CMD_RAW : (r < 65) ? CMD_TEXT : CMD_NUM;
        raw  = 8'($urandom_range(255));
        text = $urandom();
        cnt  = 3'($urandom_range(7));
        num  = ($urandom_range(1) == 1) ? 16'($urandom_range(9999))
                                        : 16'($urandom_range(65535));
        sep  = 1'($urandom_range(1));
        offer(cmd, raw, text, cnt, num, sep);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(CMD_RAW,  8'h00, "    ", 3'd0, 16'd0,     1'b0);
        offer(CMD_RAW,  8'hFF, "    ", 3'd0, 16'd0,     1'b1);
        offer(CMD_RAW,  8'hA5, "    ", 3'd0, 16'd0,     1'b0);
        offer(CMD_IDLE, 8'hFF, "ABCD", 3'd4, 16'd1234,  1'b1);
        offer(CMD_TEXT, 8'h00, "8888", 3'd0, 16'd0,     1'b1);
        offer(CMD_TEXT, 8'h00, "H   ", 3'd1, 16'd0,     1'b1);
        offer(CMD_TEXT, 8'h00, "-,  ", 3'd2, 16'd0,     1'b1);
        offer(CMD_TEXT, 8'h00, "ABCD", 3'd4, 16'd0,     1'b0);
        offer(CMD_TEXT, 8'h00, "zyxw", 3'd4, 16'd0,     1'b1);
        offer(CMD_TEXT, 8'h00, {8'd127, 8'd0, "_", "."}, 3'd7, 16'd0, 1'b1);
        offer(CMD_TEXT, 8'h00, "09@[", 3'd5, 16'd0,     1'b0);
        offer(CMD_TEXT, 8'h00, "`{/:", 3'd4, 16'd0,     1'b1);
        offer(CMD_TEXT, 8'h00, "Mn5Q", 3'd3, 16'd0,     1'b1);
        offer(CMD_NUM,  8'h00, "    ", 3'd0, 16'd0,     1'b0);
        offer(CMD_NUM,  8'h00, "    ", 3'd0, 16'd9999,  1'b1);
        offer(CMD_NUM,  8'h00, "    ", 3'd0, 16'd10000, 1'b0);
        offer(CMD_NUM,  8'h00, "    ", 3'd0, 16'd65535, 1'b1);
        offer(CMD_NUM,  8'h00, "    ", 3'd7, 16'd12345, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle <= (ph == 0) ? 8 : (ph == 1) ? 57 : 0;
            recv_idle <= (ph == 0) ? 57 : (ph == 1) ? 8 : 0;
            if (ph == 2) begin
                hold_req <= ~hold_req;
            end
            repeat (PER_PHASE) offer_random();
        end
        i_valid <= 1'b0;

        @(negedge i_clk);
        while (events_due != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && events_due == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/ssdw_pkg.sv
sv/ssdw_front.sv
sv/ssdw_fifo.sv
sv/ssdw_back.sv
sv/seven_segment_serial_display_writer_unit.sv
tb/sv/ssdw_link_event_checker.sv
tb/sv/tb_seven_segment_serial_display_writer_unit.sv
